[design/i2c_master_transfer_sequencer_top_defines.svh]
// Assertion macros shared by the I2C master transfer sequencer RTL.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define I2CMTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define I2CMTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/i2cmts_pkg.sv]
// Types and constants for the I2C master transfer sequencer.
`default_nettype none

package i2cmts_pkg;

	localparam int unsigned TX_DEPTH_DEF = 64;
	localparam int unsigned RX_MAX_DEF   = 255;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_EVENT = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_NAK     = 3'd1,
		ST_ARB     = 3'd2,
		ST_BUSERR  = 3'd3,
		ST_BUSY    = 3'd4,
		ST_ADDRNAK = 3'd5
	} xfer_status_t;

	// control register bits: start, stop, interrupt, ack
	localparam logic [3:0] CTL_ACK   = 4'b0001;
	localparam logic [3:0] CTL_INT   = 4'b0010;
	localparam logic [3:0] CTL_STOP  = 4'b0100;
	localparam logic [3:0] CTL_START = 4'b1000;
	localparam logic [3:0] CTL_ALL   = 4'b1111;

	// controller status codes, low three bits zero
	localparam logic [7:0] SC_BUS_ERR      = 8'h00;
	localparam logic [7:0] SC_START        = 8'h08;
	localparam logic [7:0] SC_RSTART       = 8'h10;
	localparam logic [7:0] SC_TX_ADDR_ACK  = 8'h18;
	localparam logic [7:0] SC_TX_ADDR_NACK = 8'h20;
	localparam logic [7:0] SC_TX_DATA_ACK  = 8'h28;
	localparam logic [7:0] SC_TX_DATA_NACK = 8'h30;
	localparam logic [7:0] SC_ARB_LOST     = 8'h38;
	localparam logic [7:0] SC_RX_ADDR_ACK  = 8'h40;
	localparam logic [7:0] SC_RX_ADDR_NACK = 8'h48;
	localparam logic [7:0] SC_RX_DATA_ACK  = 8'h50;
	localparam logic [7:0] SC_RX_DATA_NACK = 8'h58;

endpackage

`default_nettype wire

[design/i2cmts_cmd_if.sv]
// Command channel: loads, transfer starts and bus status events.
`default_nettype none

interface i2cmts_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] byte_in;
	logic [7:0] status_code;
	logic [6:0] slave_addr;
	logic [6:0] tx_count;
	logic [7:0] rx_count;

	modport source (
		output valid, op, byte_in, status_code, slave_addr, tx_count, rx_count,
		input  ready
	);
	modport sink (
		input  valid, op, byte_in, status_code, slave_addr, tx_count, rx_count,
		output ready
	);
endinterface

`default_nettype wire

[design/i2cmts_rsp_if.sv]
// Response channel: bus data, control masks, received byte and status.
`default_nettype none

interface i2cmts_rsp_if;
	logic       valid;
	logic       ready;
	logic       data_write;
	logic [7:0] data_out;
	logic [3:0] control_set;
	logic [3:0] control_clear;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic [2:0] xfer_status;
	logic       still_active;

	modport source (
		output valid, data_write, data_out, control_set, control_clear,
		       rx_valid, rx_byte, xfer_status, still_active,
		input  ready
	);
	modport sink (
		input  valid, data_write, data_out, control_set, control_clear,
		       rx_valid, rx_byte, xfer_status, still_active,
		output ready
	);
endinterface

`default_nettype wire

[design/i2c_master_transfer_sequencer_top.sv]
// I2C master transfer sequencer: top level with transmit byte memory.
//
// Steps one I2C master write, read or write-then-read transfer. Load transactions
// fill a TX_DEPTH-byte transmit memory; a start transaction latches the target
// address and byte counts (transmit count clipped to the bytes loaded, receive
// count clipped to RX_MAX) and reports busy; each status event transaction
// returns the next bus data byte, set/clear masks for the controller's start,
// stop, interrupt and ack bits, any received byte and the transfer status.
// Every command transaction yields exactly one response transaction. The block
// takes one transaction per clock while the response register is free or being
// taken; the response appears in the cycle after acceptance, since the transmit
// byte comes from a synchronous memory whose single read port is registered in
// the response stage. Counters and status sit in flops and are updated at the
// acceptance edge, so a byte loaded in one transaction is readable by the very
// next one. Transmit memory contents are undefined after reset; only loaded
// entries are ever read. When a transfer ends (stop requested or arbitration
// lost) the load and read indexes return to zero.
`default_nettype none

`include "i2c_master_transfer_sequencer_top_defines.svh"

module i2c_master_transfer_sequencer_top #(
	parameter int unsigned TX_DEPTH = i2cmts_pkg::TX_DEPTH_DEF,
	parameter int unsigned RX_MAX   = i2cmts_pkg::RX_MAX_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	i2cmts_cmd_if.sink    cmd,
	i2cmts_rsp_if.source  rsp
);
	import i2cmts_pkg::*;

	// index into the memory, and a counter that can also hold TX_DEPTH itself
	localparam int unsigned TX_IW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int unsigned TX_CW = $clog2(TX_DEPTH + 1);
	localparam int unsigned RX_W  = $clog2(RX_MAX + 1);

	// ---------------------------------------------------------------- state
	logic [7:0]       tx_mem [TX_DEPTH];
	logic [TX_CW-1:0] load_idx_q, rd_idx_q, tx_rem_q;
	logic [RX_W-1:0]  rx_rem_q;
	logic [6:0]       target_q;
	xfer_status_t     st_q;

	// response stage
	logic       v_s1;
	logic       dw_s1;
	logic       dsel_s1;      // data byte comes from the memory read
	logic [7:0] dout_s1;
	logic [7:0] rdata_s1;
	logic [3:0] cs_s1, cc_s1;
	logic       rv_s1;
	logic [7:0] rb_s1;
	logic [2:0] xs_s1;
	logic       act_s1;

	// ---------------------------------------------------------------- next state
	logic             acc;
	logic [7:0]       code;
	logic [TX_CW-1:0] load_nxt, rd_nxt, tx_rem_nxt;
	logic [RX_W-1:0]  rx_rem_nxt;
	logic [6:0]       target_nxt;
	xfer_status_t     st_nxt;
	logic [3:0]       keep;
	logic             wr_en, rd_en;
	logic             dw, dsel, rv, act, xfer_end;
	logic [7:0]       dout, rb;
	logic [3:0]       cs, cc;

	// response register frees up whenever the downstream side takes it
	assign cmd.ready = !v_s1 || rsp.ready;
	assign acc       = cmd.valid && cmd.ready;
	assign code      = {cmd.status_code[7:3], 3'b000};

	always_comb begin
		load_nxt   = load_idx_q;
		rd_nxt     = rd_idx_q;
		tx_rem_nxt = tx_rem_q;
		rx_rem_nxt = rx_rem_q;
		target_nxt = target_q;
		st_nxt     = st_q;
		keep       = CTL_ALL;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		dw         = 1'b0;
		dsel       = 1'b0;
		dout       = 8'h00;
		rv         = 1'b0;
		rb         = 8'h00;
		cs         = 4'h0;
		cc         = 4'h0;
		act        = (st_q == ST_BUSY);
		xfer_end   = 1'b0;

		case (op_t'(cmd.op))
			OP_LOAD: begin
				// loads past the end of the memory are dropped
				if (load_idx_q < TX_CW'(TX_DEPTH)) begin
					wr_en    = 1'b1;
					load_nxt = load_idx_q + TX_CW'(1);
				end
			end
			OP_START: begin
				if (st_q != ST_BUSY) begin
					target_nxt = cmd.slave_addr;
					tx_rem_nxt = (32'(cmd.tx_count) < 32'(load_idx_q)) ?
						TX_CW'(cmd.tx_count) : load_idx_q;
					rx_rem_nxt = (32'(cmd.rx_count) < 32'(RX_MAX)) ?
						RX_W'(cmd.rx_count) : RX_W'(RX_MAX);
					rd_nxt     = '0;
					st_nxt     = ST_BUSY;
					cs         = CTL_START;
				end
				act = 1'b1;
			end
			OP_EVENT: begin
				if (st_q != ST_BUSY) begin
					cc  = CTL_ALL & ~CTL_STOP;
					act = 1'b0;
				end else begin
					case (code)
						SC_START, SC_RSTART: begin
							// address byte, read bit set when nothing left to send
							dw   = 1'b1;
							dout = {target_q, (tx_rem_q == '0)};
						end
						SC_TX_ADDR_ACK, SC_TX_DATA_ACK: begin
							if (tx_rem_q == '0) begin
								// writes done: repeated start for a read, else stop
								keep = keep & ~((rx_rem_q != '0) ? CTL_START : CTL_STOP);
							end else begin
								dw         = 1'b1;
								dsel       = 1'b1;
								rd_en      = 1'b1;
								rd_nxt     = rd_idx_q + TX_CW'(1);
								tx_rem_nxt = tx_rem_q - TX_CW'(1);
							end
						end
						SC_RX_DATA_NACK, SC_RX_DATA_ACK, SC_RX_ADDR_ACK: begin
							if (code == SC_RX_DATA_NACK) begin
								keep = keep & ~CTL_STOP;
							end
							if (code != SC_RX_ADDR_ACK) begin
								rv = 1'b1;
								rb = cmd.byte_in;
								if (rx_rem_q != '0) begin
									rx_rem_nxt = rx_rem_q - RX_W'(1);
								end
							end
							// ack all but the last byte
							if (rx_rem_nxt > RX_W'(1)) begin
								keep = keep & ~CTL_ACK;
							end
						end
						SC_TX_ADDR_NACK, SC_RX_ADDR_NACK: begin
							st_nxt = ST_ADDRNAK;
							keep   = keep & ~CTL_STOP;
						end
						SC_TX_DATA_NACK: begin
							st_nxt = ST_NAK;
							keep   = keep & ~CTL_STOP;
						end
						SC_ARB_LOST: begin
							st_nxt = ST_ARB;
						end
						SC_BUS_ERR: begin
							st_nxt = ST_BUSERR;
							keep   = keep & ~CTL_STOP;
						end
						default: begin
						end
					endcase

					act = 1'b1;
					if (!keep[2] || st_nxt == ST_ARB) begin
						xfer_end = 1'b1;
						if (st_nxt == ST_BUSY) begin
							st_nxt = ST_DONE;
						end
						act      = 1'b0;
						load_nxt = '0;
						rd_nxt   = '0;
					end
					cs = ~keep;
					cc = keep & ~CTL_STOP;
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx_q <= '0;
			rd_idx_q   <= '0;
			tx_rem_q   <= '0;
			rx_rem_q   <= '0;
			target_q   <= '0;
			st_q       <= ST_DONE;
		end else if (acc) begin
			load_idx_q <= load_nxt;
			rd_idx_q   <= rd_nxt;
			tx_rem_q   <= tx_rem_nxt;
			rx_rem_q   <= rx_rem_nxt;
			target_q   <= target_nxt;
			st_q       <= st_nxt;
		end
	end

	// transmit memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (acc && wr_en) begin
			tx_mem[load_idx_q[TX_IW-1:0]] <= cmd.byte_in;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && rd_en) begin
			rdata_s1 <= tx_mem[rd_idx_q[TX_IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.ready) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			dw_s1   <= dw;
			dsel_s1 <= dsel;
			dout_s1 <= dout;
			cs_s1   <= cs;
			cc_s1   <= cc;
			rv_s1   <= rv;
			rb_s1   <= rb;
			xs_s1   <= st_nxt;
			act_s1  <= act;
		end
	end

	// ---------------------------------------------------------------- response
	assign rsp.valid         = v_s1;
	assign rsp.data_write    = dw_s1;
	assign rsp.data_out      = dsel_s1 ? rdata_s1 : dout_s1;
	assign rsp.control_set   = cs_s1;
	assign rsp.control_clear = cc_s1;
	assign rsp.rx_valid      = rv_s1;
	assign rsp.rx_byte       = rb_s1;
	assign rsp.xfer_status   = xs_s1;
	assign rsp.still_active  = act_s1;

	// ---------------------------------------------------------------- checks
	`I2CMTS_ASSERT_NOW(a_load_in_range, 1'b1, 32'(load_idx_q) <= 32'(TX_DEPTH), "load index past memory depth")
	`I2CMTS_ASSERT_NOW(a_read_loaded, acc && rd_en, rd_idx_q < load_idx_q, "read of a transmit byte never loaded")
	`I2CMTS_ASSERT_NEXT(a_end_clears, acc && xfer_end, load_idx_q == '0 && rd_idx_q == '0 && st_q != ST_BUSY, "transfer end left indexes or busy status")
	`I2CMTS_ASSERT_NEXT(a_resp_held, v_s1 && !rsp.ready, v_s1, "pending response dropped")

endmodule

`default_nettype wire
